// ===== rtl/sde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound register delta encoder package
// Shared types, codes and constants of the delta encoder.
// ----------------------------------------------------------------------------
package sde_pkg;

	// Default number of registers that are kept and compared per chip.
	localparam int COMPARED_REGS_DEF = 13;

	// Envelope shape register, never stored, skipped on the skip value.
	localparam logic [3:0] ENV_REG  = 4'd13;
	localparam logic [7:0] ENV_SKIP = 8'hFF;

	// Address tags for pairs that go to one chip only.
	localparam logic [5:0] TAG_A = 6'h10;
	localparam logic [5:0] TAG_B = 6'h20;

	// Operation codes of an input word; the fourth code is ignored.
	typedef enum logic [1:0] {
		OP_FULL   = 2'd0,
		OP_SINGLE = 2'd1,
		OP_DUAL   = 2'd2
	} op_t;

	// One input word.
	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] reg_index;
		logic [7:0] value_a;
		logic [7:0] value_b;
	} item_t;

	// One address/value pair.
	typedef struct packed {
		logic [5:0] addr_byte;
		logic [7:0] data_byte;
	} pair_t;

	// Encoder result for one input word.
	typedef struct packed {
		logic [1:0] cnt;
		pair_t      p0;
		pair_t      p1;
		logic       we;
		logic [7:0] wa;
		logic [7:0] wb;
	} enc_t;

	// Status of the result buffer.
	typedef struct packed {
		logic       free;
		logic [1:0] cnt;
	} buf_stat_t;

endpackage

// ===== rtl/sde_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound register delta encoder channels
// Valid/ready channels for input words and for address/value pairs.
// ----------------------------------------------------------------------------

// Input word channel.
interface sde_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [3:0] reg_index;
	logic [7:0] value_a;
	logic [7:0] value_b;

	modport source (output valid, opcode, reg_index, value_a, value_b, input ready);
	modport sink (input valid, opcode, reg_index, value_a, value_b, output ready);
endinterface

// Address/value pair channel.
interface sde_pair_if;
	logic       valid;
	logic       ready;
	logic [5:0] addr_byte;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, addr_byte, data_byte, last, input ready);
	modport sink (input valid, addr_byte, data_byte, last, output ready);
endinterface

// ===== rtl/sound_register_delta_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound register delta encoder
// Turns sound-chip register words into address/value pairs for a serial link,
// dropping writes that do not change the kept register values.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word                                        | Handshake
//  items   | in        | opcode, reg_index, value_a, value_b         | valid/ready
//  pairs   | out       | addr_byte, data_byte, last                  | valid/ready
//
//  A word is registered, decided combinationally against the stores, and its
//  pairs go to the result buffer, which hands out one pair per cycle while
//  pairs is ready. A new word can load as the last pair of the one before
//  is taken, so a word with two pairs holds the buffer until both are taken.
//  Reset clears both stores and all valid state at once; no clearing pass.
//  A stall on pairs holds the buffer and then the input register.
// ----------------------------------------------------------------------------
module sound_register_delta_encoder import sde_pkg::*; #(
	parameter int COMPARED_REGS = COMPARED_REGS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	sde_item_if.sink items,
	sde_pair_if.source pairs
);

	logic       valid_s1;
	item_t      item_s1;
	logic       advance;
	logic [7:0] prev_a;
	logic [7:0] prev_b;
	enc_t       enc;
	buf_stat_t  stat;

	// A word leaves the input register when its pairs fit in the buffer.
	assign advance     = valid_s1 && (stat.free || enc.cnt == 2'd0);
	assign items.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= '{opcode: items.opcode, reg_index: items.reg_index,
				value_a: items.value_a, value_b: items.value_b};
		end
	end

	// Register stores.
	sde_store #(
		.COMPARED_REGS(COMPARED_REGS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.idx   (item_s1.reg_index),
		.we    (advance && enc.we),
		.wa    (enc.wa),
		.wb    (enc.wb),
		.rd_a  (prev_a),
		.rd_b  (prev_b)
	);

	// Decision logic.
	sde_encode #(
		.COMPARED_REGS(COMPARED_REGS)
	) u_encode (
		.item  (item_s1),
		.prev_a(prev_a),
		.prev_b(prev_b),
		.enc   (enc)
	);

	// Result buffer.
	sde_outbuf u_outbuf (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (advance && enc.cnt != 2'd0),
		.enc   (enc),
		.stat  (stat),
		.pairs (pairs)
	);

	// The buffer never holds more than two pairs.
	assert property (@(posedge clk) disable iff (!arst_n) stat.cnt != 2'd3)
		else $error("result buffer count out of range");

	// The second pair of a word follows right after the first is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		pairs.valid && pairs.ready && !pairs.last |=> pairs.valid)
		else $error("second pair of a word missing");

	// A held word keeps its payload until it can move on.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("held input word lost or changed");

	// The buffer is only loaded when it is empty or drains in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && enc.cnt != 2'd0 |-> stat.free)
		else $error("result buffer overwritten");

endmodule

// ===== rtl/sde_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound register delta encoder store
// Last written values of the compared registers for chip A and chip B.
// ----------------------------------------------------------------------------
module sde_store import sde_pkg::*; #(
	parameter int COMPARED_REGS = COMPARED_REGS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] idx,
	input  logic       we,
	input  logic [7:0] wa,
	input  logic [7:0] wb,
	output logic [7:0] rd_a,
	output logic [7:0] rd_b
);

	localparam int AW = (COMPARED_REGS > 1) ? $clog2(COMPARED_REGS) : 1;

	logic [7:0] prev_a_q [COMPARED_REGS];
	logic [7:0] prev_b_q [COMPARED_REGS];
	logic [AW-1:0] addr;

	assign addr = idx[AW-1:0];

	// The encoder only uses the read data for an index inside the store.
	assign rd_a = prev_a_q[addr];
	assign rd_b = prev_b_q[addr];

	// Both stores clear at reset and take at most one entry per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMPARED_REGS; i++) begin
				prev_a_q[i] <= '0;
				prev_b_q[i] <= '0;
			end
		end else if (we) begin
			prev_a_q[addr] <= wa;
			prev_b_q[addr] <= wb;
		end
	end

endmodule

// ===== rtl/sde_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound register delta encoder decision logic
// Compares one word against the stores and builds zero, one or two pairs.
// ----------------------------------------------------------------------------
module sde_encode import sde_pkg::*; #(
	parameter int COMPARED_REGS = COMPARED_REGS_DEF
) (
	input  item_t      item,
	input  logic [7:0] prev_a,
	input  logic [7:0] prev_b,
	output enc_t       enc
);

	logic       is_env;
	logic       in_rng;
	logic       ch_a;
	logic       ch_b_single;
	logic       ch_b_dual;
	logic       a_ok;
	logic       b_ok;
	logic       emit_sh;
	logic       emit_a;
	logic       emit_b;
	logic       wr_en;
	logic [7:0] wr_a;
	logic [7:0] wr_b;
	logic [1:0] out_cnt;
	pair_t      out_p0;
	pair_t      out_p1;
	logic [5:0] base;
	pair_t      pair_sh;
	pair_t      pair_a;
	pair_t      pair_b;

	// Classify the register and compare against the stored values.
	assign is_env      = item.reg_index == ENV_REG;
	assign in_rng      = !is_env && (item.reg_index < 4'(COMPARED_REGS));
	assign ch_a        = item.value_a != prev_a;
	assign ch_b_single = item.value_a != prev_b;
	assign ch_b_dual   = item.value_b != prev_b;
	assign a_ok        = item.value_a != ENV_SKIP;
	assign b_ok        = item.value_b != ENV_SKIP;

	// Decide which pairs are sent and what the stores take.
	always_comb begin
		emit_sh = 1'b0;
		emit_a  = 1'b0;
		emit_b  = 1'b0;
		wr_en   = 1'b0;
		wr_a    = item.value_a;
		wr_b    = item.value_a;
		unique case (op_t'(item.opcode))
			OP_FULL, OP_SINGLE: begin
				if (is_env) begin
					emit_sh = a_ok;
				end else if (in_rng) begin
					emit_sh = (op_t'(item.opcode) == OP_FULL) || ch_a || ch_b_single;
					wr_en   = 1'b1;
				end
			end
			OP_DUAL: begin
				wr_b = item.value_b;
				if (is_env) begin
					if (a_ok && b_ok && item.value_a == item.value_b) begin
						emit_sh = 1'b1;
					end else begin
						emit_a = a_ok;
						emit_b = b_ok;
					end
				end else if (in_rng) begin
					wr_en = 1'b1;
					if (ch_a && ch_b_dual && item.value_a == item.value_b) begin
						emit_sh = 1'b1;
					end else begin
						emit_a = ch_a;
						emit_b = ch_b_dual;
					end
				end
			end
			default: begin
				emit_sh = 1'b0;
			end
		endcase
	end

	// Form the pairs and pack them in emission order.
	assign base    = {2'b00, item.reg_index};
	assign pair_sh = '{addr_byte: base, data_byte: item.value_a};
	assign pair_a  = '{addr_byte: base | TAG_A, data_byte: item.value_a};
	assign pair_b  = '{addr_byte: base | TAG_B, data_byte: item.value_b};

	always_comb begin
		out_cnt = 2'd0;
		out_p0  = pair_sh;
		out_p1  = pair_b;
		if (emit_sh) begin
			out_cnt = 2'd1;
		end else if (emit_a) begin
			out_p0  = pair_a;
			out_cnt = emit_b ? 2'd2 : 2'd1;
		end else if (emit_b) begin
			out_p0  = pair_b;
			out_cnt = 2'd1;
		end
	end

	assign enc = '{cnt: out_cnt, p0: out_p0, p1: out_p1, we: wr_en, wa: wr_a, wb: wr_b};

endmodule

// ===== rtl/sde_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound register delta encoder result buffer
// Two-entry buffer that hands the pairs of one word out one per cycle while pairs is ready.
// ----------------------------------------------------------------------------
module sde_outbuf import sde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  enc_t      enc,
	output buf_stat_t stat,
	sde_pair_if.source pairs
);

	logic [1:0] cnt_q;
	pair_t      slot0_q;
	pair_t      slot1_q;
	logic       last0_q;
	logic       pop;

	assign pop  = pairs.valid && pairs.ready;
	// The buffer can take a new word when it is empty after this cycle.
	assign stat = '{free: (cnt_q == 2'd0) || (cnt_q == 2'd1 && pairs.ready), cnt: cnt_q};

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= enc.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Pair payload; the second pair moves up after the first is taken.
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= enc.p0;
			slot1_q <= enc.p1;
			last0_q <= enc.cnt == 2'd1;
		end else if (pop && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
			last0_q <= 1'b1;
		end
	end

	assign pairs.valid     = cnt_q != 2'd0;
	assign pairs.addr_byte = slot0_q.addr_byte;
	assign pairs.data_byte = slot0_q.data_byte;
	assign pairs.last      = last0_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound register delta encoder testbench
// Drives register words through the encoder under several idle and stall
// patterns, including one long hold-off on the pair channel. A scoreboard
// keeps its own copy of both chip stores, predicts the address/value pairs of
// every accepted word and checks each returned pair in order.
// ----------------------------------------------------------------------------
module testbench;
	import sde_pkg::*;

	// The fourth opcode is unused and must be ignored by the block.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Register numbers used by the directed words.
	localparam logic [3:0] REG_FIRST     = 4'd0;
	localparam logic [3:0] REG_NEXT      = 4'd1;
	localparam logic [3:0] REG_MID       = 4'd3;
	localparam logic [3:0] REG_LAST_KEPT = 4'(COMPARED_REGS_DEF - 1);
	localparam logic [3:0] REG_OUT_LO    = ENV_REG + 4'd1;
	localparam logic [3:0] REG_OUT_HI    = 4'hF;

	localparam int RANDOM_PER_PHASE = 330;
	localparam int HOLD_OFF_CYCLES  = 250;
	localparam int DRAIN_LIMIT      = 20000;

	// One predicted pair.
	typedef struct {
		logic [5:0] addr;
		logic [7:0] data;
		logic       last;
	} pair_pred_t;

	// Scoreboard: mirrors both register stores and checks pairs in order.
	class pair_scoreboard;
		logic [7:0] chip_a_regs [COMPARED_REGS_DEF];
		logic [7:0] chip_b_regs [COMPARED_REGS_DEF];
		pair_pred_t pending[$];
		int         errors;
		int         pairs_checked;
		int         tagged_pairs;

		function new();
			foreach (chip_a_regs[i]) begin
				chip_a_regs[i] = 8'h00;
				chip_b_regs[i] = 8'h00;
			end
			errors = 0;
			pairs_checked = 0;
			tagged_pairs = 0;
		endfunction

		function void push_pair(logic [5:0] addr, logic [7:0] data);
			pair_pred_t p;
			p.addr = addr;
			p.data = data;
			p.last = 1'b0;
			pending.push_back(p);
		endfunction

		// Work out the pairs that one accepted word causes.
		function void note_word(logic [1:0] op, logic [3:0] idx, logic [7:0] va,
				logic [7:0] vb);
			int         first;
			logic       chg_a;
			logic       chg_b;
			logic [5:0] base;
			first = pending.size();
			base = {2'b00, idx};
			if (op == OP_UNUSED) begin
				return;
			end
			if (idx == ENV_REG) begin
				// The envelope shape register is never stored; the skip value emits nothing.
				if (op == OP_DUAL) begin
					if (va != ENV_SKIP && vb != ENV_SKIP && va == vb) begin
						push_pair(base, va);
					end else begin
						if (va != ENV_SKIP) push_pair(base | TAG_A, va);
						if (vb != ENV_SKIP) push_pair(base | TAG_B, vb);
					end
				end else if (va != ENV_SKIP) begin
					push_pair(base, va);
				end
			end else if (idx < COMPARED_REGS_DEF) begin
				chg_a = (va != chip_a_regs[idx]);
				if (op == OP_FULL) begin
					push_pair(base, va);
					chip_a_regs[idx] = va;
					chip_b_regs[idx] = va;
				end else if (op == OP_SINGLE) begin
					chg_b = (va != chip_b_regs[idx]);
					if (chg_a || chg_b) push_pair(base, va);
					chip_a_regs[idx] = va;
					chip_b_regs[idx] = va;
				end else begin
					// Both chips moved to one value: a shared pair, else one pair per changed chip.
					chg_b = (vb != chip_b_regs[idx]);
					if (chg_a && chg_b && va == vb) begin
						push_pair(base, va);
					end else begin
						if (chg_a) push_pair(base | TAG_A, va);
						if (chg_b) push_pair(base | TAG_B, vb);
					end
					chip_a_regs[idx] = va;
					chip_b_regs[idx] = vb;
				end
			end
			if (pending.size() > first) begin
				pending[pending.size() - 1].last = 1'b1;
			end
		endfunction

		// Compare one returned pair with the oldest prediction.
		function void check_pair(logic [5:0] addr, logic [7:0] data, logic last_flag);
			pair_pred_t want;
			pairs_checked++;
			if (addr[5:4] != 2'b00) tagged_pairs++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected pair, addr %h data %h last %b",
					$time, addr, data, last_flag);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (addr !== want.addr) begin
				$display("%0t: addr_byte expected %h actual %h", $time, want.addr, addr);
				errors++;
			end
			if (data !== want.data) begin
				$display("%0t: data_byte expected %h actual %h", $time, want.data, data);
				errors++;
			end
			if (last_flag !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, last_flag);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sde_item_if items_ch ();
	sde_pair_if pairs_ch ();

	sound_register_delta_encoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.pairs  (pairs_ch)
	);

	pair_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int words_sent     = 0;
	int words_ignored  = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#4_000_000;
		$display("sound_register_delta_encoder verification failed");
		$finish;
	end

	// Pair receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		pairs_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_left > 0) begin
				pairs_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				pairs_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
			@(posedge clk);
			if (pairs_ch.valid && pairs_ch.ready) begin
				sb.check_pair(pairs_ch.addr_byte, pairs_ch.data_byte, pairs_ch.last);
			end
		end
	end

	// Offer one word after a random idle gap and wait until it is taken.
	task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
			input logic [7:0] va, input logic [7:0] vb);
		while ($urandom_range(99) < send_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid     <= 1'b1;
		items_ch.opcode    <= op;
		items_ch.reg_index <= idx;
		items_ch.value_a   <= va;
		items_ch.value_b   <= vb;
		do @(posedge clk); while (!items_ch.ready);
		sb.note_word(op, idx, va, vb);
		words_sent++;
		if (op == OP_UNUSED || (idx != ENV_REG && idx >= COMPARED_REGS_DEF)) begin
			words_ignored++;
		end
	endtask

	// Value that often repeats the kept one, so unchanged writes are common.
	function automatic logic [7:0] pick_value(input logic [7:0] kept);
		int sel;
		sel = $urandom_range(99);
		if (sel < 30) return kept;
		if (sel < 40) return ENV_SKIP;
		if (sel < 45) return 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// Random words, mostly well formed, until the phase count of useful words is met.
	task automatic random_phase(input int count);
		int         done_cnt;
		int         sel;
		logic [1:0] op;
		logic [3:0] idx;
		logic [7:0] va;
		logic [7:0] vb;
		done_cnt = 0;
		while (done_cnt < count) begin
			sel = $urandom_range(99);
			op = (sel < 4) ? OP_UNUSED : 2'($urandom_range(2));
			sel = $urandom_range(99);
			if (sel < 4) idx = 4'($urandom_range(15, 14));
			else if (sel < 16) idx = ENV_REG;
			else idx = 4'($urandom_range(COMPARED_REGS_DEF - 1));
			if (idx < COMPARED_REGS_DEF) begin
				va = pick_value(sb.chip_a_regs[idx]);
				vb = ($urandom_range(99) < 30) ? va : pick_value(sb.chip_b_regs[idx]);
			end else begin
				va = pick_value(8'($urandom_range(255)));
				vb = ($urandom_range(99) < 30) ? va : pick_value(8'($urandom_range(255)));
			end
			send_word(op, idx, va, vb);
			if (op != OP_UNUSED && (idx == ENV_REG || idx < COMPARED_REGS_DEF)) begin
				done_cnt++;
			end
		end
	endtask

	// Main sequence.
	initial begin
		int drain;
		arst_n             <= 1'b0;
		items_ch.valid     <= 1'b0;
		items_ch.opcode    <= OP_FULL;
		items_ch.reg_index <= REG_FIRST;
		items_ch.value_a   <= 8'h00;
		items_ch.value_b   <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: cleared stores, every mode, unchanged writes and the envelope cases.
		send_word(OP_SINGLE, REG_FIRST, 8'h00, 8'hFF);
		send_word(OP_DUAL, REG_NEXT, 8'h00, 8'h00);
		send_word(OP_FULL, REG_FIRST, 8'h00, 8'h5A);
		send_word(OP_FULL, REG_LAST_KEPT, 8'hFF, 8'h00);
		send_word(OP_SINGLE, REG_LAST_KEPT, 8'hFF, 8'h12);
		send_word(OP_SINGLE, REG_LAST_KEPT, 8'h00, 8'hFF);
		send_word(OP_DUAL, REG_MID, 8'hA5, 8'hA5);
		send_word(OP_DUAL, REG_MID, 8'h11, 8'h22);
		send_word(OP_DUAL, REG_MID, 8'h11, 8'h33);
		send_word(OP_DUAL, REG_MID, 8'h44, 8'h33);
		send_word(OP_DUAL, REG_MID, 8'h55, 8'h44);
		send_word(OP_SINGLE, REG_MID, 8'h55, 8'hC3);
		send_word(OP_DUAL, REG_LAST_KEPT, 8'hFF, 8'hFF);
		send_word(OP_FULL, ENV_REG, ENV_SKIP, 8'h00);
		send_word(OP_FULL, ENV_REG, 8'h0E, 8'hFF);
		send_word(OP_SINGLE, ENV_REG, ENV_SKIP, 8'h01);
		send_word(OP_SINGLE, ENV_REG, 8'h00, 8'hFF);
		send_word(OP_DUAL, ENV_REG, 8'h0A, 8'h0A);
		send_word(OP_DUAL, ENV_REG, ENV_SKIP, ENV_SKIP);
		send_word(OP_DUAL, ENV_REG, ENV_SKIP, 8'h05);
		send_word(OP_DUAL, ENV_REG, 8'h05, ENV_SKIP);
		send_word(OP_DUAL, ENV_REG, 8'h01, 8'h02);
		send_word(OP_UNUSED, REG_MID, 8'h77, 8'h88);
		send_word(OP_FULL, REG_OUT_LO, 8'h99, 8'h66);
		send_word(OP_DUAL, REG_OUT_HI, 8'hAA, 8'h55);

		// Back-to-back words against a long output hold-off, so the input stalls.
		hold_left = HOLD_OFF_CYCLES;
		random_phase(RANDOM_PER_PHASE);

		send_idle_pct  = 71;
		recv_stall_pct = 0;
		random_phase(RANDOM_PER_PHASE);

		send_idle_pct  = 0;
		recv_stall_pct = 71;
		random_phase(RANDOM_PER_PHASE);

		send_idle_pct  = 35;
		recv_stall_pct = 35;
		random_phase(RANDOM_PER_PHASE);

		items_ch.valid <= 1'b0;

		// Drain the outstanding pairs, then keep watching for stray ones.
		drain = 0;
		while (sb.pending.size() > 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending.size() > 0) begin
			$display("%0t: %0d predicted pairs never arrived", $time, sb.pending.size());
			sb.errors++;
		end

		$display("Sent %0d words (%0d of them ignored) and checked %0d pairs (%0d tagged),",
			words_sent, words_ignored, sb.pairs_checked, sb.tagged_pairs);
		$display("under four idle/stall mixes and one long hold-off on the pair side.");
		if (sb.errors == 0) begin
			$display("sound_register_delta_encoder verification clean");
		end else begin
			$display("sound_register_delta_encoder verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sde_pkg.sv
rtl/sde_if.sv
rtl/sde_store.sv
rtl/sde_encode.sv
rtl/sde_outbuf.sv
rtl/sound_register_delta_encoder.sv
bench/testbench.sv
